### rtl/url_percent_decoder_defines.svh
// Assertion macros for the checks in the decoder top level.
`ifndef URL_PERCENT_DECODER_DEFINES_SVH
`define URL_PERCENT_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UPD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/upd_pkg.sv
package upd_pkg;

    localparam int UPD_QDEPTH = 2;

    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CASE_MASK  = 8'hdf;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_run_end;
        logic       out_stream_end;
    } t_out_item;

    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
        logic            last;
    } t_run;

    typedef struct packed {
        logic push;
        t_run run;
    } t_push;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

### rtl/upd_front.sv
module upd_front
    import upd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    input  t_q_status i_q_status,
    output t_push     o_push
);

    t_phase     r_phase, n_phase, w_mid_phase;
    logic [7:0] r_held, n_held, w_mid_held;
    logic       w_accept;
    logic [7:0] w_b;
    logic       w_hex, w_plus, w_pct;
    t_run       w_run;

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h41) begin
            v = (c & CASE_MASK) - 8'h41 + 8'd10;
        end else begin
            v = c - 8'h30;
        end
        return v[3:0];
    endfunction

    assign w_accept = i_in_valid && !i_q_status.full;
    assign w_b      = i_in_data.in_byte;
    assign w_plus   = (w_b == CH_PLUS);
    assign w_pct    = (w_b == CH_PERCENT);
    assign w_hex    = ((w_b >= 8'h30) && (w_b <= 8'h39)) ||
                      ((w_b >= 8'h41) && (w_b <= 8'h46)) ||
                      ((w_b >= 8'h61) && (w_b <= 8'h66));

    always_comb begin
        w_mid_held  = r_held;
        w_mid_phase = w_pct ? PH_PCT : PH_IDLE;
        unique case (r_phase)
            PH_PCT: begin
                if (w_hex) begin
                    w_mid_phase = PH_DIGIT;
                    w_mid_held  = w_b;
                end
            end
            PH_DIGIT: begin
                if (w_hex) begin
                    w_mid_phase = PH_IDLE;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (i_in_data.in_last) begin
            n_phase = PH_IDLE;
            n_held  = 8'd0;
        end else begin
            n_phase = w_mid_phase;
            n_held  = w_mid_held;
        end
    end

    always_comb begin
        logic [1:0] cnt;
        logic       do_plain;
        cnt      = 2'd0;
        do_plain = 1'b1;
        w_run    = '0;
        unique case (r_phase)
            PH_PCT: begin
                if (w_hex) begin
                    do_plain = 1'b0;
                end else begin
                    w_run.bytes[cnt] = CH_PERCENT;
                    cnt = cnt + 2'd1;
                end
            end
            PH_DIGIT: begin
                if (w_hex) begin
                    do_plain = 1'b0;
                    w_run.bytes[cnt] = {hex_val(r_held), hex_val(w_b)};
                    cnt = cnt + 2'd1;
                end else begin
                    w_run.bytes[cnt] = CH_PERCENT;
                    cnt = cnt + 2'd1;
                    w_run.bytes[cnt] = r_held;
                    cnt = cnt + 2'd1;
                end
            end
            default: begin
            end
        endcase
        if (do_plain && !w_pct) begin
            w_run.bytes[cnt] = w_plus ? CH_SPACE : w_b;
            cnt = cnt + 2'd1;
        end
        if (i_in_data.in_last) begin
            if (w_mid_phase == PH_PCT) begin
                w_run.bytes[cnt] = CH_PERCENT;
                cnt = cnt + 2'd1;
            end else if (w_mid_phase == PH_DIGIT) begin
                w_run.bytes[cnt] = CH_PERCENT;
                cnt = cnt + 2'd1;
                w_run.bytes[cnt] = w_mid_held;
                cnt = cnt + 2'd1;
            end
        end
        w_run.count = cnt;
        w_run.last  = i_in_data.in_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 8'd0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    assign o_push.push = w_accept && (w_run.count != 2'd0);
    assign o_push.run  = w_run;

endmodule

### rtl/upd_queue.sv
module upd_queue
    import upd_pkg::*;
#(
    parameter int QDEPTH = UPD_QDEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    input  logic      i_pop,
    output t_run      o_head,
    output t_q_status o_status
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QDEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QDEPTH);

    t_run          r_mem [QDEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        return (p == LAST_PTR) ? '0 : p + PW'(1);
    endfunction

    always_comb begin
        n_cnt = r_cnt;
        if (i_push.push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!i_push.push && i_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_next(r_rd);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.run;
        end
    end

    assign o_head         = r_mem[r_rd];
    assign o_status.empty = (r_cnt == '0);
    assign o_status.full  = (r_cnt == FULL_CNT);

endmodule

### rtl/upd_back.sv
module upd_back
    import upd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_run      i_head,
    input  t_q_status i_q_status,
    input  logic      i_out_stall,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    logic [1:0] r_idx, n_idx;
    logic       w_take, w_run_end;
    logic [7:0] w_byte;

    always_comb begin
        unique case (r_idx)
            2'd0:    w_byte = i_head.bytes[0];
            2'd1:    w_byte = i_head.bytes[1];
            default: w_byte = i_head.bytes[2];
        endcase
    end

    assign o_out_valid = !i_q_status.empty;
    assign w_take      = o_out_valid && !i_out_stall;
    assign w_run_end   = (r_idx == (i_head.count - 2'd1));
    assign o_pop       = w_take && w_run_end;

    always_comb begin
        n_idx = r_idx;
        if (w_take) begin
            n_idx = w_run_end ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else begin
            r_idx <= n_idx;
        end
    end

    assign o_out_data.out_byte       = w_byte;
    assign o_out_data.out_run_end    = w_run_end;
    assign o_out_data.out_stream_end = w_run_end && i_head.last;

endmodule

### rtl/url_percent_decoder.sv
// Channel  | Direction | Handshake                 | Payload
// input    | in        | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
// output   | out       | o_out_valid / i_out_stall | o_out_data (t_out_item)
//
// One input transaction is taken per cycle while the run queue has room.
// Each input yields zero to three bytes; the output sequencer sends one byte
// per cycle while i_out_stall is low.
// A queue of QDEPTH runs lies between the classifier and the sequencer.
// Reset clears the escape phase, the queue pointers and the byte index.
// o_in_stall is high only while the run queue is full.
`include "url_percent_decoder_defines.svh"

module url_percent_decoder
    import upd_pkg::*;
#(
    parameter int QDEPTH = UPD_QDEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    t_push     w_push;
    t_run      w_head;
    t_q_status w_status;
    logic      w_pop;

    upd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_q_status (w_status),
        .o_push     (w_push)
    );

    upd_queue #(
        .QDEPTH (QDEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_status)
    );

    upd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_q_status  (w_status),
        .i_out_stall (i_out_stall),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign o_in_stall = w_status.full;

    `UPD_ASSERT_SAME(a_last_yields, i_in_valid && !o_in_stall && i_in_data.in_last, w_push.push, "final input produced no byte")
    `UPD_ASSERT_SAME(a_stream_end_in_run, o_out_valid && o_out_data.out_stream_end, o_out_data.out_run_end, "stream end outside a run end")
    `UPD_ASSERT_NEXT(a_run_continues, o_out_valid && !i_out_stall && !o_out_data.out_run_end, o_out_valid, "run broken off mid-way")
    `UPD_ASSERT_SAME(a_push_room, w_push.push, !w_status.full, "push into a full queue")

endmodule

### tb/url_percent_decoder_test.sv
`timescale 1ns / 1ps

module url_percent_decoder_test;
    import upd_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int HOLD_CYCLES    = 40;
    localparam int PHASE_ITEMS    = 95;
    localparam int DIR_ROWS       = 24;

    typedef enum logic [1:0] {
        ROW_PREDICT = 2'd0,
        ROW_SILENT  = 2'd1,
        ROW_SINGLE  = 2'd2
    } t_row_kind;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
        t_row_kind  kind;
        logic [7:0] single;
    } t_dir_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_item  i_in_data;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      i_out_stall = 1'b0;

    url_percent_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    t_phase     dec_phase = PH_IDLE;
    logic [7:0] dec_held  = 8'h00;
    logic [7:0] decoded_run[$];
    t_out_item  decoded_expect[$];
    logic [7:0] token_bytes[$];

    t_row_kind  row_kind   = ROW_PREDICT;
    logic [7:0] row_single = 8'h00;
    int         send_gap_pct   = 0;
    int         recv_stall_pct = 0;
    int         hold_requests  = 0;
    int         hold_served    = 0;
    int         hold_left      = 0;
    int         mismatches     = 0;
    int         quiet_cycles   = 0;

    t_dir_row dir_tbl[DIR_ROWS] = '{
        '{8'h61,      1'b0, ROW_SINGLE,  8'h61},
        '{CH_PLUS,    1'b0, ROW_SINGLE,  CH_SPACE},
        '{8'h00,      1'b0, ROW_SINGLE,  8'h00},
        '{8'hff,      1'b0, ROW_SINGLE,  8'hff},
        '{CH_PERCENT, 1'b0, ROW_SILENT,  8'h00},
        '{8'h34,      1'b0, ROW_SILENT,  8'h00},
        '{8'h31,      1'b0, ROW_SINGLE,  8'h41},
        '{CH_PERCENT, 1'b0, ROW_SILENT,  8'h00},
        '{8'h61,      1'b0, ROW_SILENT,  8'h00},
        '{8'h46,      1'b0, ROW_PREDICT, 8'h00},
        '{CH_PERCENT, 1'b0, ROW_SILENT,  8'h00},
        '{8'h47,      1'b0, ROW_PREDICT, 8'h00},
        '{CH_PERCENT, 1'b0, ROW_SILENT,  8'h00},
        '{CH_PLUS,    1'b0, ROW_PREDICT, 8'h00},
        '{CH_PERCENT, 1'b0, ROW_SILENT,  8'h00},
        '{CH_PERCENT, 1'b0, ROW_PREDICT, 8'h00},
        '{8'h34,      1'b0, ROW_SILENT,  8'h00},
        '{8'h7a,      1'b0, ROW_PREDICT, 8'h00},
        '{CH_PERCENT, 1'b0, ROW_SILENT,  8'h00},
        '{8'h34,      1'b0, ROW_SILENT,  8'h00},
        '{CH_PERCENT, 1'b0, ROW_PREDICT, 8'h00},
        '{8'h32,      1'b1, ROW_PREDICT, 8'h00},
        '{CH_PERCENT, 1'b1, ROW_SINGLE,  CH_PERCENT},
        '{8'h78,      1'b1, ROW_SINGLE,  8'h78}
    };

    function automatic void add_decoded(input logic [7:0] b);
        decoded_run.insert(decoded_run.size(), b);
    endfunction

    function automatic void add_token(input logic [7:0] b);
        token_bytes.insert(token_bytes.size(), b);
    endfunction

    function automatic void add_expect(input t_out_item it);
        decoded_expect.insert(decoded_expect.size(), it);
    endfunction

    function automatic logic is_hex_digit(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h41) begin
            v = (c & CASE_MASK) - 8'h37;
        end else begin
            v = c - 8'h30;
        end
        return v[3:0];
    endfunction

    function automatic void decode_plain(input logic [7:0] b);
        if (b == CH_PLUS) begin
            add_decoded(CH_SPACE);
        end else if (b == CH_PERCENT) begin
            dec_phase = PH_PCT;
        end else begin
            add_decoded(b);
        end
    endfunction

    function automatic void decode_step(input logic [7:0] b, input logic last);
        decoded_run.delete();
        case (dec_phase)
            PH_PCT: begin
                if (is_hex_digit(b)) begin
                    dec_held  = b;
                    dec_phase = PH_DIGIT;
                end else begin
                    add_decoded(CH_PERCENT);
                    dec_phase = PH_IDLE;
                    decode_plain(b);
                end
            end
            PH_DIGIT: begin
                dec_phase = PH_IDLE;
                if (is_hex_digit(b)) begin
                    add_decoded({nibble_of(dec_held), nibble_of(b)});
                end else begin
                    add_decoded(CH_PERCENT);
                    add_decoded(dec_held);
                    decode_plain(b);
                end
            end
            default: begin
                dec_phase = PH_IDLE;
                decode_plain(b);
            end
        endcase
        if (last) begin
            if (dec_phase == PH_PCT) begin
                add_decoded(CH_PERCENT);
            end else if (dec_phase == PH_DIGIT) begin
                add_decoded(CH_PERCENT);
                add_decoded(dec_held);
            end
            dec_phase = PH_IDLE;
            dec_held  = 8'h00;
        end
    endfunction

    function automatic logic [7:0] random_hex_digit();
        logic [7:0] v;
        v = 8'($urandom_range(15));
        if (v < 8'd10) begin
            return 8'h30 + v;
        end
        return ($urandom_range(1) ? 8'h41 : 8'h61) + v - 8'd10;
    endfunction

    function automatic logic [7:0] random_non_hex();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (is_hex_digit(b)) begin
            b = 8'($urandom_range(255));
        end
        return b;
    endfunction

    // Random plain bytes, plus signs, well-formed escapes with random digits, and broken and bare escapes.
    function automatic void queue_token();
        int r;
        r = $urandom_range(99);
        if (r < 30) begin
            add_token(8'($urandom_range(255)));
        end else if (r < 40) begin
            add_token(CH_PLUS);
        end else if (r < 75) begin
            add_token(CH_PERCENT);
            add_token(random_hex_digit());
            add_token(random_hex_digit());
        end else if (r < 85) begin
            add_token(CH_PERCENT);
            add_token(random_non_hex());
        end else if (r < 95) begin
            add_token(CH_PERCENT);
            add_token(random_hex_digit());
            add_token(random_non_hex());
        end else begin
            add_token(CH_PERCENT);
        end
    endfunction

    task automatic offer(input t_in_item item, input t_row_kind kind,
                         input logic [7:0] single);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        row_kind    = kind;
        row_single  = single;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic run_random(input int count);
        t_in_item item;
        int sent;
        sent = 0;
        while (sent < count) begin
            if (token_bytes.size() == 0) begin
                queue_token();
            end
            item.in_byte = token_bytes.pop_front();
            item.in_last = ($urandom_range(19) == 0);
            offer(item, ROW_PREDICT, 8'h00);
            sent++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever begin
            #(CLK_PERIOD / 2) i_clk = ~i_clk;
        end
    end

    always @(negedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_in_item  took;
        t_out_item want;
        logic      moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                took  = i_in_data;
                decode_step(took.in_byte, took.in_last);
                case (row_kind)
                    ROW_SILENT: begin
                    end
                    ROW_SINGLE: begin
                        want.out_byte       = row_single;
                        want.out_run_end    = 1'b1;
                        want.out_stream_end = took.in_last;
                        add_expect(want);
                    end
                    default: begin
                        for (int k = 0; k < decoded_run.size(); k++) begin
                            want.out_byte       = decoded_run[k];
                            want.out_run_end    = (k == decoded_run.size() - 1);
                            want.out_stream_end = want.out_run_end && took.in_last;
                            add_expect(want);
                        end
                    end
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (decoded_expect.size() == 0) begin
                    $display("%0t: unexpected output transaction, got %02h/%b/%b", $time,
                             o_out_data.out_byte, o_out_data.out_run_end,
                             o_out_data.out_stream_end);
                    mismatches++;
                end else begin
                    want = decoded_expect.pop_front();
                    if (o_out_data.out_byte !== want.out_byte) begin
                        $display("%0t: out_byte expected %02h, got %02h", $time,
                                 want.out_byte, o_out_data.out_byte);
                        mismatches++;
                    end
                    if (o_out_data.out_run_end !== want.out_run_end) begin
                        $display("%0t: out_run_end expected %b, got %b", $time,
                                 want.out_run_end, o_out_data.out_run_end);
                        mismatches++;
                    end
                    if (o_out_data.out_stream_end !== want.out_stream_end) begin
                        $display("%0t: out_stream_end expected %b, got %b", $time,
                                 want.out_stream_end, o_out_data.out_stream_end);
                        mismatches++;
                    end
                end
            end
            if (moved) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    initial begin
        t_in_item item;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_gap_pct   = 22;
        recv_stall_pct = 86;
        for (int i = 0; i < DIR_ROWS; i++) begin
            item.in_byte = dir_tbl[i].in_byte;
            item.in_last = dir_tbl[i].in_last;
            offer(item, dir_tbl[i].kind, dir_tbl[i].single);
        end
        run_random(PHASE_ITEMS);

        send_gap_pct   = 86;
        recv_stall_pct = 22;
        run_random(PHASE_ITEMS);

        // The receiver holds off for a long stretch so that the run queue fills.
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_requests++;
        run_random(PHASE_ITEMS);

        i_in_valid <= 1'b0;
        while (decoded_expect.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/upd_pkg.sv
rtl/upd_front.sv
rtl/upd_queue.sv
rtl/upd_back.sv
rtl/url_percent_decoder.sv
tb/url_percent_decoder_test.sv
